// ----- hdl/fault_latch_with_history_ring_core_defines.svh -----
// Assertion macros for the fault latch core.
// Each macro takes a label, the clock, the reset, an antecedent and a consequent.
`ifndef FAULT_LATCH_WITH_HISTORY_RING_CORE_DEFINES_SVH
`define FAULT_LATCH_WITH_HISTORY_RING_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent
`define FLHR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flhr assertion failed");

// Consequent must hold in the cycle after the antecedent
`define FLHR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flhr assertion failed");

`else

`define FLHR_ASSERT_SAME(label, clk, rst, ante, cons)
`define FLHR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/flhr_pkg.sv -----
`timescale 1ns / 1ps

package flhr_pkg;

  // Field widths
  localparam int MODE_W   = 3;
  localparam int FCODE_W  = 6;
  localparam int OFFSET_W = 5;
  localparam int STATUS_W = 2;
  localparam int MASK_W   = 37;
  localparam int HCOUNT_W = 6;
  localparam int WORD_W   = 32;
  localparam int BYTE_W   = 8;
  localparam int PACK_W   = 64;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_RAISE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_KILL     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_KILL_ALL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_LOG = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_CTX = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOCHG   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADCODE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADOFF  = 2'd3;

  // Stored context: ids pack timestamp, slave, cell, channel, contactor;
  // vals pack measured and threshold
  typedef struct packed {
    logic [PACK_W-1:0] ids;
    logic [PACK_W-1:0] vals;
  } ctx_entry_t;

  typedef struct packed {
    logic                en;
    logic [FCODE_W-1:0]  addr;
    ctx_entry_t          data;
  } ctx_wr_t;

  // One event in the history ring
  typedef struct packed {
    logic [FCODE_W-1:0]  code;
    logic                raised;
    ctx_entry_t          ctx;
  } log_entry_t;

  typedef struct packed {
    logic        en;
    log_entry_t  entry;
  } log_wr_t;

endpackage

// ----- hdl/flhr_ctx_store.sv -----
`timescale 1ns / 1ps

module flhr_ctx_store #(
  parameter int NUM_FAULTS = 37
) (
  input  logic                          clk,
  input  logic                          rst,
  input  flhr_pkg::ctx_wr_t             wr,
  input  logic                          rd_en,
  input  logic [flhr_pkg::FCODE_W-1:0]  rd_addr,
  output flhr_pkg::ctx_entry_t          rd_data
);
  import flhr_pkg::*;

  localparam int CODE_W = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;

  ctx_entry_t              mem [NUM_FAULTS];
  logic [NUM_FAULTS-1:0]   vld;
  ctx_entry_t              rd_q;
  logic                    rd_vld;

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[CODE_W-1:0]] <= wr.data;
    end
  end

  // Track written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.addr[CODE_W-1:0]] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= mem[rd_addr[CODE_W-1:0]];
      rd_vld <= vld[rd_addr[CODE_W-1:0]];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

// ----- hdl/flhr_log_ring.sv -----
`timescale 1ns / 1ps

module flhr_log_ring #(
  parameter int LOG_DEPTH = 32,
  parameter int HCNT_W    = $clog2(LOG_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  flhr_pkg::log_wr_t              wr,
  input  logic                           rd_en,
  input  logic [flhr_pkg::OFFSET_W-1:0]  rd_offset,
  output logic                           offset_ok,
  output logic [HCNT_W-1:0]              count,
  output flhr_pkg::log_entry_t           rd_data
);
  import flhr_pkg::*;

  localparam int SLOT_W = $clog2(LOG_DEPTH);
  localparam int ADD_W  = ((SLOT_W > OFFSET_W) ? SLOT_W : OFFSET_W) + 1;

  log_entry_t         mem [LOG_DEPTH];
  logic [SLOT_W-1:0]  oldest;
  logic [SLOT_W-1:0]  next_slot;
  logic [ADD_W-1:0]   slot_sum;
  logic [SLOT_W-1:0]  rd_slot;

  // Offset is only served below the fill count
  assign offset_ok = ADD_W'(rd_offset) < ADD_W'(count);

  // Wrap oldest + offset; the sum stays below twice the depth
  assign slot_sum = ADD_W'(oldest) + ADD_W'(rd_offset);
  assign rd_slot  = (slot_sum >= ADD_W'(LOG_DEPTH)) ?
                    SLOT_W'(slot_sum - ADD_W'(LOG_DEPTH)) : SLOT_W'(slot_sum);

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[next_slot] <= wr.entry;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_slot];
    end
  end

  // Advance ring pointers; drop the oldest entry once full
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest    <= '0;
      next_slot <= '0;
      count     <= '0;
    end else if (wr.en) begin
      next_slot <= (next_slot == SLOT_W'(LOG_DEPTH - 1)) ? '0 : next_slot + SLOT_W'(1);
      if (count < HCNT_W'(LOG_DEPTH)) begin
        count <= count + HCNT_W'(1);
      end else begin
        oldest <= (oldest == SLOT_W'(LOG_DEPTH - 1)) ? '0 : oldest + SLOT_W'(1);
      end
    end
  end

endmodule

// ----- hdl/fault_latch_with_history_ring_core.sv -----
// Raise, kill of an inactive fault, bad code, bad offset, unused modes: S_EXEC, then the
// result is loaded from S_FIN. Kill of an active fault adds S_KWR, history read S_HRD,
// context read S_CRD. Kill all walks S_SCAN one fault code per cycle through the single
// context read port, with an S_KWR log write step per active fault. A new item is
// taken once the previous result sits in the output register, so output stalls hold
// off the next item. Reset (rst, synchronous) clears control state, flags and pointers.
`timescale 1ns / 1ps
`include "fault_latch_with_history_ring_core_defines.svh"

module fault_latch_with_history_ring_core #(
  parameter int NUM_FAULTS = 37,
  parameter int LOG_DEPTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [flhr_pkg::MODE_W-1:0]    mode,
  input  logic [flhr_pkg::FCODE_W-1:0]   fault_code,
  input  logic [flhr_pkg::OFFSET_W-1:0]  history_offset,
  input  logic [flhr_pkg::WORD_W-1:0]    ctx_timestamp,
  input  logic [flhr_pkg::BYTE_W-1:0]    ctx_slave,
  input  logic [flhr_pkg::BYTE_W-1:0]    ctx_cell,
  input  logic [flhr_pkg::BYTE_W-1:0]    ctx_channel,
  input  logic [flhr_pkg::BYTE_W-1:0]    ctx_contactor,
  input  logic [flhr_pkg::WORD_W-1:0]    ctx_measured,
  input  logic [flhr_pkg::WORD_W-1:0]    ctx_threshold,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [flhr_pkg::STATUS_W-1:0]  status,
  output logic [flhr_pkg::MASK_W-1:0]    active_mask,
  output logic [flhr_pkg::HCOUNT_W-1:0]  history_count,
  output logic [flhr_pkg::FCODE_W-1:0]   entry_code,
  output logic                           entry_raised,
  output logic [flhr_pkg::WORD_W-1:0]    out_timestamp,
  output logic [flhr_pkg::BYTE_W-1:0]    out_slave,
  output logic [flhr_pkg::BYTE_W-1:0]    out_cell,
  output logic [flhr_pkg::BYTE_W-1:0]    out_channel,
  output logic [flhr_pkg::BYTE_W-1:0]    out_contactor,
  output logic [flhr_pkg::WORD_W-1:0]    out_measured,
  output logic [flhr_pkg::WORD_W-1:0]    out_threshold
);
  import flhr_pkg::*;

  localparam int CODE_W = (NUM_FAULTS > 1) ? $clog2(NUM_FAULTS) : 1;
  localparam int IDX_W  = $clog2(NUM_FAULTS + 1);
  localparam int HCNT_W = $clog2(LOG_DEPTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_KWR  = 3'd3;
  localparam logic [2:0] S_HRD  = 3'd4;
  localparam logic [2:0] S_CRD  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]             state, state_next;
  logic [MODE_W-1:0]      mode_q;
  logic [FCODE_W-1:0]     code_q;
  logic [OFFSET_W-1:0]    offset_q;
  ctx_entry_t             ctx_q;

  logic [NUM_FAULTS-1:0]  active_bits, active_bits_next;
  logic [IDX_W-1:0]       scan_idx, scan_idx_next;
  logic                   kill_any, kill_any_next;
  logic                   kill_single, kill_single_next;

  logic [STATUS_W-1:0]    res_status, res_status_next;
  logic [FCODE_W-1:0]     res_code, res_code_next;
  logic                   res_raised, res_raised_next;
  ctx_entry_t             res_ctx, res_ctx_next;

  ctx_wr_t                ctx_wr;
  logic                   ctx_rd_en;
  logic [FCODE_W-1:0]     ctx_rd_addr;
  ctx_entry_t             ctx_rd_data;

  log_wr_t                log_wr;
  logic                   log_rd_en;
  logic                   offset_ok;
  logic [HCNT_W-1:0]      hist_count;
  log_entry_t             log_rd_data;

  logic                   code_ok;
  logic [CODE_W-1:0]      code_idx;
  logic [CODE_W-1:0]      scan_code;
  logic                   scan_done;
  logic                   out_load;

  assign in_ready  = (state == S_IDLE);
  assign code_ok   = {1'b0, code_q} < 7'(NUM_FAULTS);
  assign code_idx  = code_q[CODE_W-1:0];
  assign scan_code = scan_idx[CODE_W-1:0];
  assign scan_done = (scan_idx == IDX_W'(NUM_FAULTS));
  assign out_load  = (state == S_FIN) && (!out_valid || out_ready);

  flhr_ctx_store #(
    .NUM_FAULTS (NUM_FAULTS)
  ) u_ctx (
    .clk     (clk),
    .rst     (rst),
    .wr      (ctx_wr),
    .rd_en   (ctx_rd_en),
    .rd_addr (ctx_rd_addr),
    .rd_data (ctx_rd_data)
  );

  flhr_log_ring #(
    .LOG_DEPTH (LOG_DEPTH),
    .HCNT_W    (HCNT_W)
  ) u_log (
    .clk       (clk),
    .rst       (rst),
    .wr        (log_wr),
    .rd_en     (log_rd_en),
    .rd_offset (offset_q),
    .offset_ok (offset_ok),
    .count     (hist_count),
    .rd_data   (log_rd_data)
  );

  // Sequencer: each state makes at most one access to each memory
  always_comb begin
    state_next       = state;
    active_bits_next = active_bits;
    scan_idx_next    = scan_idx;
    kill_any_next    = kill_any;
    kill_single_next = kill_single;
    res_status_next  = res_status;
    res_code_next    = res_code;
    res_raised_next  = res_raised;
    res_ctx_next     = res_ctx;
    ctx_wr           = '0;
    ctx_rd_en        = 1'b0;
    ctx_rd_addr      = code_q;
    log_wr           = '0;
    log_rd_en        = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_code_next   = '0;
          res_raised_next = 1'b0;
          res_ctx_next    = '0;
          state_next      = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next      = S_FIN;
        res_status_next = ST_BADCODE;
        case (mode_q)
          MODE_RAISE: begin
            if (code_ok) begin
              ctx_wr.en   = 1'b1;
              ctx_wr.addr = code_q;
              ctx_wr.data = ctx_q;
              if (!active_bits[code_idx]) begin
                active_bits_next[code_idx] = 1'b1;
                log_wr.en                  = 1'b1;
                log_wr.entry.code          = code_q;
                log_wr.entry.raised        = 1'b1;
                log_wr.entry.ctx           = ctx_q;
                res_status_next            = ST_OK;
              end else begin
                res_status_next = ST_NOCHG;
              end
            end
          end
          MODE_KILL: begin
            if (code_ok) begin
              if (active_bits[code_idx]) begin
                ctx_rd_en        = 1'b1;
                scan_idx_next    = IDX_W'(code_q);
                kill_single_next = 1'b1;
                state_next       = S_KWR;
              end else begin
                res_status_next = ST_NOCHG;
              end
            end
          end
          MODE_KILL_ALL: begin
            scan_idx_next    = '0;
            kill_any_next    = 1'b0;
            kill_single_next = 1'b0;
            state_next       = S_SCAN;
          end
          MODE_READ_LOG: begin
            if (offset_ok) begin
              log_rd_en  = 1'b1;
              state_next = S_HRD;
            end else begin
              res_status_next = ST_BADOFF;
            end
          end
          MODE_READ_CTX: begin
            if (code_ok) begin
              ctx_rd_en  = 1'b1;
              state_next = S_CRD;
            end
          end
          default: begin
            res_status_next = ST_BADCODE;
          end
        endcase
      end

      // Walk fault codes in ascending order
      S_SCAN: begin
        if (scan_done) begin
          res_status_next = kill_any ? ST_OK : ST_NOCHG;
          state_next      = S_FIN;
        end else if (active_bits[scan_code]) begin
          ctx_rd_en   = 1'b1;
          ctx_rd_addr = FCODE_W'(scan_idx);
          state_next  = S_KWR;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end

      // Log the cleared event with the stored context, drop the bit
      S_KWR: begin
        log_wr.en                   = 1'b1;
        log_wr.entry.code           = FCODE_W'(scan_idx);
        log_wr.entry.raised         = 1'b0;
        log_wr.entry.ctx            = ctx_rd_data;
        active_bits_next[scan_code] = 1'b0;
        kill_any_next               = 1'b1;
        if (kill_single) begin
          res_status_next = ST_OK;
          state_next      = S_FIN;
        end else begin
          scan_idx_next = scan_idx + IDX_W'(1);
          state_next    = S_SCAN;
        end
      end

      S_HRD: begin
        res_status_next = ST_OK;
        res_code_next   = log_rd_data.code;
        res_raised_next = log_rd_data.raised;
        res_ctx_next    = log_rd_data.ctx;
        state_next      = S_FIN;
      end

      S_CRD: begin
        res_status_next = ST_OK;
        res_code_next   = code_q;
        res_ctx_next    = ctx_rd_data;
        state_next      = S_FIN;
      end

      S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active_bits <= '0;
      scan_idx    <= '0;
      kill_any    <= 1'b0;
      kill_single <= 1'b0;
    end else begin
      state       <= state_next;
      active_bits <= active_bits_next;
      scan_idx    <= scan_idx_next;
      kill_any    <= kill_any_next;
      kill_single <= kill_single_next;
    end
  end

  // Hold the accepted item and the result being built
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q   <= mode;
      code_q   <= fault_code;
      offset_q <= history_offset;
      ctx_q    <= '{ids:  {ctx_timestamp, ctx_slave, ctx_cell, ctx_channel, ctx_contactor},
                    vals: {ctx_measured, ctx_threshold}};
    end
    res_status <= res_status_next;
    res_code   <= res_code_next;
    res_raised <= res_raised_next;
    res_ctx    <= res_ctx_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status        <= res_status;
      active_mask   <= MASK_W'(active_bits);
      history_count <= HCOUNT_W'(hist_count);
      entry_code    <= res_code;
      entry_raised  <= res_raised;
      out_timestamp <= res_ctx.ids[63:32];
      out_slave     <= res_ctx.ids[31:24];
      out_cell      <= res_ctx.ids[23:16];
      out_channel   <= res_ctx.ids[15:8];
      out_contactor <= res_ctx.ids[7:0];
      out_measured  <= res_ctx.vals[63:32];
      out_threshold <= res_ctx.vals[31:0];
    end
  end

  // Checks
  `FLHR_ASSERT_NEXT(a_accept_exec, clk, rst, in_valid && in_ready, state == S_EXEC)
  `FLHR_ASSERT_SAME(a_kill_active, clk, rst, state == S_KWR, active_bits[scan_code])
  `FLHR_ASSERT_SAME(a_log_wr_src, clk, rst, log_wr.en, state == S_EXEC || state == S_KWR)
  `FLHR_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, hist_count <= HCNT_W'(LOG_DEPTH))
  `FLHR_ASSERT_NEXT(a_result_out, clk, rst, out_load, out_valid && state == S_IDLE)

endmodule

// ----- test/tb_fault_latch_with_history_ring_core.sv -----
`timescale 1ns / 1ps

module tb_fault_latch_with_history_ring_core;
  import flhr_pkg::*;

  localparam int CODE_COUNT   = 37;
  localparam int RING_DEPTH   = 32;
  localparam int RANDOM_ITEMS = 1330;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_CODE     = (1 << FCODE_W) - 1;
  localparam int PRINT_CAP    = 50;

  // Modes the block does not implement
  localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [FCODE_W-1:0]  code;
    logic [OFFSET_W-1:0] offset;
    logic [WORD_W-1:0]   timestamp;
    logic [BYTE_W-1:0]   slave_no;
    logic [BYTE_W-1:0]   cell_no;
    logic [BYTE_W-1:0]   chan_idx;
    logic [BYTE_W-1:0]   contactor;
    logic [WORD_W-1:0]   measured;
    logic [WORD_W-1:0]   threshold;
  } fault_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [MASK_W-1:0]   mask;
    logic [HCOUNT_W-1:0] count;
    logic [FCODE_W-1:0]  code;
    logic                raised;
    logic [WORD_W-1:0]   timestamp;
    logic [BYTE_W-1:0]   slave_no;
    logic [BYTE_W-1:0]   cell_no;
    logic [BYTE_W-1:0]   chan_idx;
    logic [BYTE_W-1:0]   contactor;
    logic [WORD_W-1:0]   measured;
    logic [WORD_W-1:0]   threshold;
  } fault_result_t;

  typedef struct {
    fault_cmd_t    cmd;
    bit            typed;
    fault_result_t res;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [MODE_W-1:0]   mode;
  logic [FCODE_W-1:0]  fault_code;
  logic [OFFSET_W-1:0] history_offset;
  logic [WORD_W-1:0]   ctx_timestamp;
  logic [BYTE_W-1:0]   ctx_slave;
  logic [BYTE_W-1:0]   ctx_cell;
  logic [BYTE_W-1:0]   ctx_channel;
  logic [BYTE_W-1:0]   ctx_contactor;
  logic [WORD_W-1:0]   ctx_measured;
  logic [WORD_W-1:0]   ctx_threshold;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [MASK_W-1:0]   active_mask;
  logic [HCOUNT_W-1:0] history_count;
  logic [FCODE_W-1:0]  entry_code;
  logic                entry_raised;
  logic [WORD_W-1:0]   out_timestamp;
  logic [BYTE_W-1:0]   out_slave;
  logic [BYTE_W-1:0]   out_cell;
  logic [BYTE_W-1:0]   out_channel;
  logic [BYTE_W-1:0]   out_contactor;
  logic [WORD_W-1:0]   out_measured;
  logic [WORD_W-1:0]   out_threshold;

  // Shadow of the latch, the stored contexts and the event ring
  logic [MASK_W-1:0] live_faults;
  ctx_entry_t        saved_ctx [CODE_COUNT];
  log_entry_t        event_ring [RING_DEPTH];
  int                ring_oldest;
  int                ring_next;
  int                ring_fill;

  fault_result_t expected_results [$];
  stim_row_t     directed_rows [$];
  int            mismatches;
  int            results_seen;
  int            source_run;
  int            sink_run;
  int            sink_stall;

  fault_latch_with_history_ring_core #(
    .NUM_FAULTS(CODE_COUNT),
    .LOG_DEPTH (RING_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .fault_code    (fault_code),
    .history_offset(history_offset),
    .ctx_timestamp (ctx_timestamp),
    .ctx_slave     (ctx_slave),
    .ctx_cell      (ctx_cell),
    .ctx_channel   (ctx_channel),
    .ctx_contactor (ctx_contactor),
    .ctx_measured  (ctx_measured),
    .ctx_threshold (ctx_threshold),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .active_mask   (active_mask),
    .history_count (history_count),
    .entry_code    (entry_code),
    .entry_raised  (entry_raised),
    .out_timestamp (out_timestamp),
    .out_slave     (out_slave),
    .out_cell      (out_cell),
    .out_channel   (out_channel),
    .out_contactor (out_contactor),
    .out_measured  (out_measured),
    .out_threshold (out_threshold)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Append one event; overwrite the oldest once the ring is full
  function automatic void log_fault_event(int code, ctx_entry_t c, bit raised);
    event_ring[ring_next].code   = code[FCODE_W-1:0];
    event_ring[ring_next].raised = raised;
    event_ring[ring_next].ctx    = c;
    ring_next = (ring_next + 1) % RING_DEPTH;
    if (ring_fill < RING_DEPTH) begin
      ring_fill++;
    end else begin
      ring_oldest = (ring_oldest + 1) % RING_DEPTH;
    end
  endfunction

  // Clear one active fault, logging its stored context as a cleared event
  function automatic bit clear_fault(int code);
    if (!live_faults[code]) return 1'b0;
    log_fault_event(code, saved_ctx[code], 1'b0);
    live_faults[code] = 1'b0;
    return 1'b1;
  endfunction

  function automatic fault_result_t with_context(fault_result_t r, ctx_entry_t c);
    {r.timestamp, r.slave_no, r.cell_no, r.chan_idx, r.contactor} = c.ids;
    {r.measured, r.threshold} = c.vals;
    return r;
  endfunction

  // Advance the shadow state by one command and return the result it yields
  function automatic fault_result_t apply_fault_cmd(fault_cmd_t c);
    fault_result_t r;
    ctx_entry_t    fresh;
    int            slot;
    bit            any_cleared;
    r = '0;
    r.status = ST_BADCODE;
    fresh.ids  = {c.timestamp, c.slave_no, c.cell_no, c.chan_idx, c.contactor};
    fresh.vals = {c.measured, c.threshold};
    case (c.mode)
      MODE_RAISE: begin
        if (c.code < CODE_COUNT) begin
          saved_ctx[c.code] = fresh;
          if (live_faults[c.code]) begin
            r.status = ST_NOCHG;
          end else begin
            live_faults[c.code] = 1'b1;
            log_fault_event(c.code, fresh, 1'b1);
            r.status = ST_OK;
          end
        end
      end
      MODE_KILL: begin
        if (c.code < CODE_COUNT) r.status = clear_fault(c.code) ? ST_OK : ST_NOCHG;
      end
      MODE_KILL_ALL: begin
        any_cleared = 1'b0;
        for (int i = 0; i < CODE_COUNT; i++) begin
          if (clear_fault(i)) any_cleared = 1'b1;
        end
        r.status = any_cleared ? ST_OK : ST_NOCHG;
      end
      MODE_READ_LOG: begin
        if (c.offset < ring_fill) begin
          slot = (ring_oldest + c.offset) % RING_DEPTH;
          r = with_context(r, event_ring[slot].ctx);
          r.code   = event_ring[slot].code;
          r.raised = event_ring[slot].raised;
          r.status = ST_OK;
        end else begin
          r.status = ST_BADOFF;
        end
      end
      MODE_READ_CTX: begin
        if (c.code < CODE_COUNT) begin
          r = with_context(r, saved_ctx[c.code]);
          r.code   = c.code;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.mask  = live_faults;
    r.count = ring_fill[HCOUNT_W-1:0];
    return r;
  endfunction

  // Spread one pattern over every context field
  function automatic fault_cmd_t make_cmd(logic [MODE_W-1:0] m, int code, int offset,
                                          logic [WORD_W-1:0] fill);
    fault_cmd_t c;
    c.mode      = m;
    c.code      = code[FCODE_W-1:0];
    c.offset    = offset[OFFSET_W-1:0];
    c.timestamp = fill;
    c.slave_no  = fill[31:24];
    c.cell_no   = fill[23:16];
    c.chan_idx  = fill[15:8];
    c.contactor = fill[7:0];
    c.measured  = ~fill;
    c.threshold = {fill[15:0], fill[31:16]};
    return c;
  endfunction

  function automatic fault_result_t mk_status(logic [STATUS_W-1:0] st,
                                              logic [MASK_W-1:0] mask, int count);
    fault_result_t r;
    r = '0;
    r.status = st;
    r.mask   = mask;
    r.count  = count[HCOUNT_W-1:0];
    return r;
  endfunction

  // Mostly no gap, some short ones, a few long; now and then a run with none
  task automatic pick_gap(inout int run, output int gap);
    int roll;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (run > 0) begin
      run--;
    end else if (roll < 6) begin
      run = $urandom_range(20, 80);
    end else if (roll >= 93) begin
      gap = $urandom_range(8, 30);
    end else if (roll >= 55) begin
      gap = $urandom_range(1, 3);
    end
  endtask

  task automatic add_row(fault_cmd_t c, bit typed, fault_result_t res);
    stim_row_t r;
    r.cmd   = c;
    r.typed = typed;
    r.res   = res;
    directed_rows.push_back(r);
  endtask

  // Present one command and hold it until the transfer, then queue its result
  task automatic drive_cmd(fault_cmd_t c, bit typed, fault_result_t typed_res);
    int            gap;
    fault_result_t predicted;
    @(negedge clk);
    pick_gap(source_run, gap);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode           = c.mode;
    fault_code     = c.code;
    history_offset = c.offset;
    ctx_timestamp  = c.timestamp;
    ctx_slave      = c.slave_no;
    ctx_cell       = c.cell_no;
    ctx_channel    = c.chan_idx;
    ctx_contactor  = c.contactor;
    ctx_measured   = c.measured;
    ctx_threshold  = c.threshold;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = apply_fault_cmd(c);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and wait for every queued result to come out
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("result %0d: %s is %0h, should be %0h", results_seen, what, got, want);
    end
    mismatches++;
  endtask

  // Result side: stall at random
  initial begin
    out_ready  = 1'b0;
    sink_run   = 0;
    sink_stall = 0;
    forever begin
      @(negedge clk);
      if (sink_stall > 0) begin
        out_ready = 1'b0;
        sink_stall--;
      end else begin
        pick_gap(sink_run, sink_stall);
        out_ready = (sink_stall == 0);
        if (sink_stall > 0) sink_stall--;
      end
    end
  end

  // Compare each result transfer with the oldest pending prediction
  always @(posedge clk) begin
    fault_result_t got;
    fault_result_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, active_mask, history_count, entry_code, entry_raised, out_timestamp,
              out_slave, out_cell, out_channel, out_contactor, out_measured, out_threshold};
      if (expected_results.size() == 0) begin
        note_mismatch("unrequested result status", got.status, '0);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) note_mismatch("status", got.status, want.status);
        if (got.mask != want.mask) note_mismatch("active_mask", got.mask, want.mask);
        if (got.count != want.count) note_mismatch("history_count", got.count, want.count);
        if (got.code != want.code) note_mismatch("entry_code", got.code, want.code);
        if (got.raised != want.raised) note_mismatch("entry_raised", got.raised, want.raised);
        if (got.timestamp != want.timestamp)
          note_mismatch("out_timestamp", got.timestamp, want.timestamp);
        if (got.slave_no != want.slave_no)
          note_mismatch("out_slave", got.slave_no, want.slave_no);
        if (got.cell_no != want.cell_no)
          note_mismatch("out_cell", got.cell_no, want.cell_no);
        if (got.chan_idx != want.chan_idx)
          note_mismatch("out_channel", got.chan_idx, want.chan_idx);
        if (got.contactor != want.contactor)
          note_mismatch("out_contactor", got.contactor, want.contactor);
        if (got.measured != want.measured)
          note_mismatch("out_measured", got.measured, want.measured);
        if (got.threshold != want.threshold)
          note_mismatch("out_threshold", got.threshold, want.threshold);
      end
      results_seen++;
    end
  end

  // End the run if no transfer happens on either side for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb_fault_latch_with_history_ring_core failed");
    $finish;
  end

  initial begin
    fault_result_t typed_res;
    fault_cmd_t    cmd;
    int            roll;
    int            start;
    rst            = 1'b1;
    in_valid       = 1'b0;
    mode           = '0;
    fault_code     = '0;
    history_offset = '0;
    ctx_timestamp  = '0;
    ctx_slave      = '0;
    ctx_cell       = '0;
    ctx_channel    = '0;
    ctx_contactor  = '0;
    ctx_measured   = '0;
    ctx_threshold  = '0;
    mismatches     = 0;
    results_seen   = 0;
    source_run     = 0;
    live_faults    = '0;
    ring_oldest    = 0;
    ring_next      = 0;
    ring_fill      = 0;
    foreach (saved_ctx[i]) saved_ctx[i] = '0;

    // Reset state: empty latch, zero contexts, empty ring; then the error codes
    add_row(make_cmd(MODE_READ_CTX, 0, 0, '0), 1'b1, mk_status(ST_OK, '0, 0));
    typed_res = mk_status(ST_OK, '0, 0);
    typed_res.code = FCODE_W'(CODE_COUNT - 1);
    add_row(make_cmd(MODE_READ_CTX, CODE_COUNT - 1, 0, '1), 1'b1, typed_res);
    add_row(make_cmd(MODE_READ_LOG, 0, 0, '1), 1'b1, mk_status(ST_BADOFF, '0, 0));
    add_row(make_cmd(MODE_KILL, 5, 0, '1), 1'b1, mk_status(ST_NOCHG, '0, 0));
    add_row(make_cmd(MODE_KILL_ALL, 0, 0, '1), 1'b1, mk_status(ST_NOCHG, '0, 0));
    add_row(make_cmd(MODE_RAISE, CODE_COUNT, 0, '1), 1'b1, mk_status(ST_BADCODE, '0, 0));
    add_row(make_cmd(MODE_RAISE, MAX_CODE, 0, '1), 1'b1, mk_status(ST_BADCODE, '0, 0));
    add_row(make_cmd(MODE_KILL, MAX_CODE, 0, '1), 1'b1, mk_status(ST_BADCODE, '0, 0));
    add_row(make_cmd(MODE_READ_CTX, CODE_COUNT, 0, '1), 1'b1,
            mk_status(ST_BADCODE, '0, 0));
    add_row(make_cmd(MODE_UNUSED_FIRST, 0, 0, '1), 1'b1, mk_status(ST_BADCODE, '0, 0));
    add_row(make_cmd(MODE_UNUSED_FIRST + 3'd1, 3, 31, '1), 1'b1,
            mk_status(ST_BADCODE, '0, 0));
    add_row(make_cmd(MODE_UNUSED_LAST, MAX_CODE, 31, '1), 1'b1,
            mk_status(ST_BADCODE, '0, 0));
    // Rising edges, a refresh of an active fault, reads, kills and kill all
    add_row(make_cmd(MODE_RAISE, 0, 0, '1), 1'b0, '0);
    add_row(make_cmd(MODE_RAISE, CODE_COUNT - 1, 0, '0), 1'b0, '0);
    add_row(make_cmd(MODE_RAISE, 0, 0, 32'h5A3C_96E1), 1'b0, '0);
    add_row(make_cmd(MODE_READ_CTX, 0, 0, '0), 1'b0, '0);
    add_row(make_cmd(MODE_READ_LOG, 0, 0, '0), 1'b0, '0);
    add_row(make_cmd(MODE_READ_LOG, 0, 1, '0), 1'b0, '0);
    add_row(make_cmd(MODE_READ_LOG, 0, 31, '0), 1'b0, '0);
    add_row(make_cmd(MODE_KILL, 0, 0, '0), 1'b0, '0);
    add_row(make_cmd(MODE_KILL, 0, 0, '0), 1'b0, '0);
    add_row(make_cmd(MODE_RAISE, 17, 0, 32'hC3A5_0F18), 1'b0, '0);
    add_row(make_cmd(MODE_KILL_ALL, 0, 0, '0), 1'b0, '0);
    add_row(make_cmd(MODE_READ_LOG, 0, 3, '0), 1'b0, '0);
    add_row(make_cmd(MODE_READ_CTX, CODE_COUNT - 1, 0, '0), 1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      drive_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
      if (n % 400 == 150) begin
        // Raise every fault from a random start, then clear them all at once
        start = $urandom_range(0, CODE_COUNT - 1);
        for (int k = 0; k < CODE_COUNT; k++) begin
          drive_cmd(make_cmd(MODE_RAISE, (start + k) % CODE_COUNT, 0, $urandom), 1'b0, '0);
        end
        drive_cmd(make_cmd(MODE_KILL_ALL, 0, 0, $urandom), 1'b0, '0);
        n += CODE_COUNT + 1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 36) begin
        cmd.mode = MODE_RAISE;
      end else if (roll < 56) begin
        cmd.mode = MODE_KILL;
      end else if (roll < 60) begin
        cmd.mode = MODE_KILL_ALL;
      end else if (roll < 78) begin
        cmd.mode = MODE_READ_LOG;
      end else if (roll < 95) begin
        cmd.mode = MODE_READ_CTX;
      end else begin
        cmd.mode = MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST));
      end
      cmd.code = FCODE_W'(($urandom_range(0, 99) < 92) ? $urandom_range(0, CODE_COUNT - 1)
                                                         : $urandom_range(CODE_COUNT, MAX_CODE));
      // Keep most history reads inside the filled part of the ring
      cmd.offset = OFFSET_W'((ring_fill > 0 && $urandom_range(0, 99) < 85)
                   ? $urandom_range(0, ring_fill - 1) : $urandom_range(0, RING_DEPTH - 1));
      cmd.timestamp = $urandom;
      cmd.slave_no  = BYTE_W'($urandom);
      cmd.cell_no   = BYTE_W'($urandom);
      cmd.chan_idx  = BYTE_W'($urandom);
      cmd.contactor = BYTE_W'($urandom);
      cmd.measured  = $urandom;
      cmd.threshold = $urandom;
      drive_cmd(cmd, 1'b0, '0);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_fault_latch_with_history_ring_core passed");
    end else begin
      $display("tb_fault_latch_with_history_ring_core failed");
    end
    $finish;
  end

endmodule
